// File: design/mdpt_pkg.sv
// Shared types and constants for the minimum-distance point thinning block.
// Used by mdpt_dist and the top module; depends on nothing else.
package mdpt_pkg;

    // Store geometry and field widths.
    localparam int MAX_SURVIVORS = 1024;
    localparam int COORD_BITS    = 24;
    localparam int DIST_BITS     = 23;
    localparam int ADDR_BITS     = $clog2(MAX_SURVIVORS);
    localparam int CNT_BITS      = ADDR_BITS + 1;

    // Arithmetic widths of the distance unit.
    localparam int SQ_BITS  = 2 * COORD_BITS;
    localparam int SUM_BITS = SQ_BITS + 2;
    localparam int R2_BITS  = 2 * DIST_BITS;

    // Configuration register map.
    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;
    localparam logic REG_SPACING = 1'b0;

    localparam logic [DIST_BITS-1:0] SPACING_RESET = DIST_BITS'(256);
    localparam logic [R2_BITS-1:0]   R2_RESET      = R2_BITS'(256 * 256);

    // One input request.
    typedef struct packed {
        logic                         first_of_set;
        logic signed [COORD_BITS-1:0] x_coord;
        logic signed [COORD_BITS-1:0] y_coord;
        logic signed [COORD_BITS-1:0] z_coord;
    } req_t;

    // One result.
    typedef struct packed {
        logic keep;
        logic store_full;
    } rsp_t;

    // One stored survivor, as held in the memory.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } point_t;

    localparam int POINT_BITS = $bits(point_t);

    // Status of the distance pipeline toward the sequencer.
    typedef struct packed {
        logic hit_valid;
        logic hit;
        logic busy;
    } dist_status_t;

endpackage

// File: design/mdpt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
module mdpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, with registered read data.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/mdpt_dist.sv
// Pipelined squared-distance compare between one survivor and the current point.
// Depends on mdpt_pkg for widths and the point and status types.
module mdpt_dist (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           issue,
    input  mdpt_pkg::point_t               entry,
    input  mdpt_pkg::point_t               point,
    input  logic [mdpt_pkg::R2_BITS-1:0]   r2,
    output mdpt_pkg::dist_status_t         status
);
    import mdpt_pkg::*;

    logic                  v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic [COORD_BITS-1:0] ax_reg, ay_reg, az_reg;
    logic [SQ_BITS-1:0]    sx_reg, sy_reg, sz_reg;
    logic [SUM_BITS-1:0]   sum_reg;
    logic                  hit_reg;

    logic [COORD_BITS:0]   dx, dy, dz;
    logic [COORD_BITS-1:0] ax_next, ay_next, az_next;

    // Absolute coordinate differences; the difference of two signed values
    // needs one more bit, its magnitude fits back in the coordinate width.
    always_comb
    begin
        dx = {entry.x[COORD_BITS-1], entry.x} - {point.x[COORD_BITS-1], point.x};
        dy = {entry.y[COORD_BITS-1], entry.y} - {point.y[COORD_BITS-1], point.y};
        dz = {entry.z[COORD_BITS-1], entry.z} - {point.z[COORD_BITS-1], point.z};
        ax_next = dx[COORD_BITS] ? COORD_BITS'(~dx + 1'b1) : dx[COORD_BITS-1:0];
        ay_next = dy[COORD_BITS] ? COORD_BITS'(~dy + 1'b1) : dy[COORD_BITS-1:0];
        az_next = dz[COORD_BITS] ? COORD_BITS'(~dz + 1'b1) : dz[COORD_BITS-1:0];
    end

    // Valid bits follow each read through the stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= issue;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Datapath: differences, squares, sum, compare.
    always_ff @(posedge clk)
    begin
        ax_reg  <= ax_next;
        ay_reg  <= ay_next;
        az_reg  <= az_next;
        sx_reg  <= SQ_BITS'(ax_reg * ax_reg);
        sy_reg  <= SQ_BITS'(ay_reg * ay_reg);
        sz_reg  <= SQ_BITS'(az_reg * az_reg);
        sum_reg <= SUM_BITS'(sx_reg) + SUM_BITS'(sy_reg) + SUM_BITS'(sz_reg);
        hit_reg <= (sum_reg <= SUM_BITS'(r2));
    end

    assign status.hit_valid = v4_reg;
    assign status.hit       = hit_reg;
    assign status.busy      = v0_reg | v1_reg | v2_reg | v3_reg | v4_reg;

endmodule

// File: design/min_distance_point_thinning_top.sv
// From an accepted request to out_valid, the survivors stored (N, at most 1024) are read
// and compared, or none with an empty store; one survivor is read and compared per
// cycle through five register stages, and a close survivor ends the scan early.
// One point at a time: the next request is taken only once the last one's result has been
// registered, and later while the previous result still waits on out_stall.
// Reset clears the survivor count and control and sets the spacing to 256; the store is not.
module min_distance_point_thinning_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  mdpt_pkg::req_t                      in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output mdpt_pkg::rsp_t                      out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mdpt_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [mdpt_pkg::PDATA_BITS-1:0]     pwdata,
    output logic [mdpt_pkg::PDATA_BITS-1:0]     prdata,
    output logic                                pready
);
    import mdpt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t                 state_reg;
    logic [DIST_BITS-1:0]   spacing_reg;
    logic [R2_BITS-1:0]     r2_reg;
    logic [CNT_BITS-1:0]    count_reg;
    logic [CNT_BITS-1:0]    idx_reg;
    logic                   hit_found_reg;
    point_t                 point_reg;
    logic                   out_valid_reg;
    rsp_t                   out_data_reg;

    dist_status_t           dist_st;
    logic [POINT_BITS-1:0]  ram_rdata;
    logic                   accept;
    logic                   issue;
    logic                   scan_done;
    logic                   out_free;
    logic                   store_ok;
    logic                   ram_we;
    logic                   finish;
    logic                   cfg_write;
    point_t                 in_point;

    // Survivor store: x, y and z of one survivor share one word.
    mdpt_ram #(
        .WIDTH (POINT_BITS),
        .DEPTH (MAX_SURVIVORS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_BITS-1:0]),
        .wdata (point_reg),
        .re    (issue),
        .raddr (idx_reg[ADDR_BITS-1:0]),
        .rdata (ram_rdata)
    );

    mdpt_dist u_dist (
        .clk    (clk),
        .rst_n  (rst_n),
        .issue  (issue),
        .entry  (point_t'(ram_rdata)),
        .point  (point_reg),
        .r2     (r2_reg),
        .status (dist_st)
    );

    // Handshakes and sequencing decisions. Reads and the write-back never
    // overlap: the store is written only once the scan has drained.
    always_comb
    begin
        accept    = in_valid && !in_stall;
        issue     = (state_reg == S_SCAN) && (idx_reg < count_reg) && !hit_found_reg
                    && !(dist_st.hit_valid && dist_st.hit);
        scan_done = (state_reg == S_SCAN) && !issue && !dist_st.busy;
        out_free  = !out_valid_reg || !out_stall;
        store_ok  = count_reg < CNT_BITS'(MAX_SURVIVORS);
        finish    = (state_reg == S_DONE) && out_free;
        ram_we    = finish && !hit_found_reg && store_ok;
        cfg_write = psel && penable && pwrite && pready;
        in_point.x = in_data.x_coord;
        in_point.y = in_data.y_coord;
        in_point.z = in_data.z_coord;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign pready    = 1'b1;

    // Register read-back.
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_SPACING)
        begin
            prdata = PDATA_BITS'(spacing_reg);
        end
    end

    // Control state, configuration and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            spacing_reg   <= SPACING_RESET;
            r2_reg        <= R2_RESET;
            count_reg     <= '0;
            idx_reg       <= '0;
            hit_found_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (cfg_write && (paddr[2] == REG_SPACING))
            begin
                spacing_reg <= pwdata[DIST_BITS-1:0];
            end
            r2_reg <= R2_BITS'(spacing_reg * spacing_reg);

            // A taken result clears the output unless a new one replaces it.
            if (out_valid_reg && !out_stall && !finish)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        idx_reg       <= '0;
                        hit_found_reg <= 1'b0;
                        if (in_data.first_of_set)
                        begin
                            count_reg <= '0;
                        end
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (issue)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    if (dist_st.hit_valid && dist_st.hit)
                    begin
                        hit_found_reg <= 1'b1;
                    end
                    if (scan_done)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (finish)
                    begin
                        if (ram_we)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        out_valid_reg           <= 1'b1;
                        out_data_reg.keep       <= !hit_found_reg;
                        out_data_reg.store_full <= !hit_found_reg && !store_ok;
                        state_reg               <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Point held for the scan and the write-back.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            point_reg <= in_point;
        end
    end

`ifndef NO_ASSERTIONS
    // The survivor count never passes the store capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(MAX_SURVIVORS))
        else $error("survivor count beyond capacity");

    // A dropped point never reports a full store.
    a_full_implies_keep: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.keep || !out_data_reg.store_full))
        else $error("store_full without keep");

    // The store is never read and written in the same cycle.
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && issue))
        else $error("store read during write-back");

    // Reads only touch stored survivors.
    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> (idx_reg < count_reg))
        else $error("read beyond stored survivors");

    // The write-back happens only once the distance pipeline has drained.
    a_drained_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !dist_st.busy)
        else $error("write-back while compares in flight");
`endif

endmodule
